[sv/mvna_pkg.sv]
`timescale 1ns / 1ps

package mvna_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int IDX_W        = 7;
  localparam int POS_W        = 16;
  localparam int ACC_W        = 40;
  localparam int NRM_W        = 16;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  // Function codes of an input word.
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } mvna_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        normal_index;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
  } mvna_out_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    mvna_in_t item;
  } mvna_q_t;

endpackage

[sv/mesh_vertex_normal_accumulate.sv]
`timescale 1ns / 1ps

// Smooth per-vertex normals by face-normal accumulation.
// Input channel in_valid/in_ready/in_data carries one command word: load a
// vertex position, add a triangle, or read and clear one vertex normal.
// Output channel out_valid/out_ready/out_data carries one normalized Q1.14
// normal for each read command; other commands give no output word.
// A four-entry command queue sits between the input side and the sequencer,
// so the input accepts until the queue is full while the sequencer works or waits.
// In the sequencer a load is written as it is taken from the queue; a triangle
// does three position reads, edges, products, cross, then a read-modify-write
// per corner; a read does a normalizing shift of one bit at a time, 3 squares,
// 32 root steps and a serial divide per component (a zero normal goes straight
// to the emit step); the serial root and divide take most of its time.
// The output of a read also waits behind any commands queued before it.
// Reset clears all accumulators at once (valid bits) and empties the queue;
// positions are undefined until loaded. When out_ready is low a finished
// result waits in the output register and the sequencer holds in its emit step.

module mesh_vertex_normal_accumulate import mvna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mvna_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mvna_out_t out_data
);

  mvna_q_t q_head;
  logic    q_pop;

  // Command queue.
  mvna_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Sequencer with stores and arithmetic.
  mvna_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/mvna_front.sv]
`timescale 1ns / 1ps

module mvna_front import mvna_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mvna_in_t in_data,
  output mvna_q_t  q_head,
  input  logic     q_pop
);

  mvna_in_t          fifo_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              push;
  logic              pop;

  // Words with the unused function code are taken and dropped here.
  assign in_ready = (count_r != (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready && (in_data.func != FUNC_UNUSED);
  assign pop      = q_pop && (count_r != '0);

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = fifo_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_data;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[sv/mvna_back.sv]
`timescale 1ns / 1ps

module mvna_back import mvna_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mvna_q_t   q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output mvna_out_t out_data
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_TRI_A    = 5'd1;
  localparam logic [4:0] S_TRI_B    = 5'd2;
  localparam logic [4:0] S_TRI_C    = 5'd3;
  localparam logic [4:0] S_TRI_E    = 5'd4;
  localparam logic [4:0] S_TRI_MUL  = 5'd5;
  localparam logic [4:0] S_TRI_CROS = 5'd6;
  localparam logic [4:0] S_ACC_RD   = 5'd7;
  localparam logic [4:0] S_ACC_WR   = 5'd8;
  localparam logic [4:0] S_RD_ACC   = 5'd9;
  localparam logic [4:0] S_RD_MAG   = 5'd10;
  localparam logic [4:0] S_RD_SHIFT = 5'd11;
  localparam logic [4:0] S_RD_SQ    = 5'd12;
  localparam logic [4:0] S_RD_ROOT  = 5'd13;
  localparam logic [4:0] S_RD_LDV   = 5'd14;
  localparam logic [4:0] S_RD_DIV   = 5'd15;
  localparam logic [4:0] S_EMIT     = 5'd16;

  localparam logic [ACC_W-1:0] M_LOW  = ACC_W'(64'd1 << 29);
  localparam logic [ACC_W-1:0] M_HIGH = ACC_W'(64'd1 << 30);
  localparam logic [14:0]      Q_CAP  = 15'd16384;

  logic [4:0]        state_r;
  logic [4:0]        state_nxt;
  mvna_in_t          item_r;

  // Position store and accumulator store.
  logic [3*POS_W-1:0] pos_mem [MAX_VERTICES];
  logic [3*POS_W-1:0] pos_rd_r;
  logic [IDX_W-1:0]   pos_addr;
  logic               pos_we;
  logic [3*ACC_W-1:0] acc_mem [MAX_VERTICES];
  logic [3*ACC_W-1:0] acc_rd_r;
  logic               acc_rd_vld_r;
  logic [MAX_VERTICES-1:0] acc_vld_r;
  logic [IDX_W-1:0]   acc_addr;
  logic               acc_we;
  logic               acc_clr;
  logic [3*ACC_W-1:0] acc_wdata;

  // Triangle datapath.
  logic [3*POS_W-1:0]      pa_r;
  logic [3*POS_W-1:0]      pb_r;
  logic signed [16:0]      e1_r [3];
  logic signed [16:0]      e2_r [3];
  logic signed [33:0]      prod_r [6];
  logic signed [34:0]      n_r [3];
  logic [1:0]              corner_r;
  logic [IDX_W-1:0]        corner_idx;

  // Normalization datapath.
  logic [ACC_W-1:0]        mag_r [3];
  logic                    neg_r [3];
  logic [ACC_W-1:0]        m_r;
  logic [1:0]              k_r;
  logic [63:0]             sq_r;
  logic [63:0]             x_r;
  logic [63:0]             res_r;
  logic [4:0]              rt_i_r;
  logic [31:0]             r_r;
  logic [46:0]             num_r;
  logic [46:0]             d_r;
  logic [14:0]             q_r;
  logic [3:0]              di_r;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic                    out_valid_r;
  mvna_out_t               out_data_r;

  logic [ACC_W-1:0]        mag_c [3];
  logic                    neg_c [3];
  logic [ACC_W-1:0]        mmax_c;
  logic [59:0]             sqr_c;
  logic [63:0]             bit_c;
  logic [63:0]             trial_c;
  logic                    root_ge;
  logic [63:0]             res_c;
  logic                    div_ge;
  logic [14:0]             qf_c;
  logic [14:0]             qc_c;
  logic                    emit_fire;

  function automatic logic signed [16:0] pcomp(input logic [3*POS_W-1:0] w, input int k);
    logic [POS_W-1:0] v;
    v = w[(2-k)*POS_W +: POS_W];
    return {v[POS_W-1], v};
  endfunction

  assign q_pop     = (state_r == S_IDLE);
  assign pos_we    = (state_r == S_IDLE) && q_head.valid && (q_head.item.func == FUNC_LOAD);
  assign acc_we    = (state_r == S_ACC_WR);
  assign acc_clr   = (state_r == S_RD_MAG);
  assign emit_fire = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Corner select for the accumulator updates.
  always_comb begin
    case (corner_r)
      2'd0:    corner_idx = item_r.corner_a;
      2'd1:    corner_idx = item_r.corner_b;
      default: corner_idx = item_r.corner_c;
    endcase
  end

  // Memory addresses.
  always_comb begin
    case (state_r)
      S_TRI_A: pos_addr = item_r.corner_a;
      S_TRI_B: pos_addr = item_r.corner_b;
      default: pos_addr = item_r.corner_c;
    endcase
    if ((state_r == S_ACC_RD) || (state_r == S_ACC_WR)) begin
      acc_addr = corner_idx;
    end else begin
      acc_addr = item_r.vertex_index;
    end
  end

  // Saturating add of the face normal; an entry not yet valid reads as zero.
  always_comb begin
    logic [ACC_W-1:0] old;
    logic [ACC_W:0]   sum;
    for (int k = 0; k < 3; k++) begin
      old = acc_rd_vld_r ? acc_rd_r[(2-k)*ACC_W +: ACC_W] : '0;
      sum = {old[ACC_W-1], old} + {{(ACC_W-34){n_r[k][34]}}, n_r[k]};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_wdata[(2-k)*ACC_W +: ACC_W] = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                     : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_wdata[(2-k)*ACC_W +: ACC_W] = sum[ACC_W-1:0];
      end
    end
  end

  // Magnitudes and signs of the accumulator being read.
  always_comb begin
    logic [ACC_W-1:0] v;
    mmax_c = '0;
    for (int k = 0; k < 3; k++) begin
      v        = acc_rd_vld_r ? acc_rd_r[(2-k)*ACC_W +: ACC_W] : '0;
      neg_c[k] = v[ACC_W-1];
      mag_c[k] = v[ACC_W-1] ? (ACC_W'(0) - v) : v;
      if (mag_c[k] > mmax_c) begin
        mmax_c = mag_c[k];
      end
    end
  end

  // Square, root step and divide step.
  assign sqr_c   = mag_r[k_r][29:0] * mag_r[k_r][29:0];
  assign bit_c   = 64'd1 << {rt_i_r, 1'b0};
  assign trial_c = res_r + bit_c;
  assign root_ge = (x_r >= trial_c);
  assign res_c   = root_ge ? ((res_r >> 1) + bit_c) : (res_r >> 1);
  assign div_ge  = (num_r >= d_r);
  assign qf_c    = {q_r[13:0], div_ge};
  assign qc_c    = (qf_c > Q_CAP) ? Q_CAP : qf_c;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          unique case (q_head.item.func)
            FUNC_TRI:  state_nxt = S_TRI_A;
            FUNC_READ: state_nxt = S_RD_ACC;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_TRI_A:    state_nxt = S_TRI_B;
      S_TRI_B:    state_nxt = S_TRI_C;
      S_TRI_C:    state_nxt = S_TRI_E;
      S_TRI_E:    state_nxt = S_TRI_MUL;
      S_TRI_MUL:  state_nxt = S_TRI_CROS;
      S_TRI_CROS: state_nxt = S_ACC_RD;
      S_ACC_RD:   state_nxt = S_ACC_WR;
      S_ACC_WR:   state_nxt = (corner_r == 2'd2) ? S_IDLE : S_ACC_RD;
      S_RD_ACC:   state_nxt = S_RD_MAG;
      S_RD_MAG:   state_nxt = (mmax_c == '0) ? S_EMIT : S_RD_SHIFT;
      S_RD_SHIFT: begin
        if ((m_r >= M_LOW) && (m_r < M_HIGH)) begin
          state_nxt = S_RD_SQ;
        end
      end
      S_RD_SQ:    state_nxt = (k_r == 2'd2) ? S_RD_ROOT : S_RD_SQ;
      S_RD_ROOT:  state_nxt = (rt_i_r == '0) ? S_RD_LDV : S_RD_ROOT;
      S_RD_LDV:   state_nxt = S_RD_DIV;
      S_RD_DIV: begin
        if (di_r == '0) begin
          state_nxt = (k_r == 2'd2) ? S_EMIT : S_RD_LDV;
        end
      end
      S_EMIT:     state_nxt = emit_fire ? S_IDLE : S_EMIT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stores: registered read ports.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[q_head.item.vertex_index] <= {q_head.item.pos_x, q_head.item.pos_y,
                                            q_head.item.pos_z};
    end
    pos_rd_r <= pos_mem[pos_addr];
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rd_r <= acc_mem[acc_addr];
  end

  // Accumulator valid bits; clearing a vertex just drops its bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r    <= '0;
      acc_rd_vld_r <= 1'b0;
    end else begin
      if (acc_we) begin
        acc_vld_r[acc_addr] <= 1'b1;
      end
      if (acc_clr) begin
        acc_vld_r[acc_addr] <= 1'b0;
      end
      acc_rd_vld_r <= acc_vld_r[acc_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        item_r   <= q_head.item;
        corner_r <= '0;
      end
      S_TRI_B: pa_r <= pos_rd_r;
      S_TRI_C: pb_r <= pos_rd_r;
      S_TRI_E: begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= pcomp(pb_r, k) - pcomp(pos_rd_r, k);
          e2_r[k] <= pcomp(pb_r, k) - pcomp(pa_r, k);
        end
      end
      S_TRI_MUL: begin
        prod_r[0] <= e1_r[1] * e2_r[2];
        prod_r[1] <= e1_r[2] * e2_r[1];
        prod_r[2] <= e1_r[2] * e2_r[0];
        prod_r[3] <= e1_r[0] * e2_r[2];
        prod_r[4] <= e1_r[0] * e2_r[1];
        prod_r[5] <= e1_r[1] * e2_r[0];
      end
      S_TRI_CROS: begin
        n_r[0] <= 35'(prod_r[0]) - 35'(prod_r[1]);
        n_r[1] <= 35'(prod_r[2]) - 35'(prod_r[3]);
        n_r[2] <= 35'(prod_r[4]) - 35'(prod_r[5]);
      end
      S_ACC_WR: corner_r <= corner_r + 1'b1;
      S_RD_MAG: begin
        for (int k = 0; k < 3; k++) begin
          mag_r[k] <= mag_c[k];
          neg_r[k] <= neg_c[k];
          nrm_r[k] <= '0;
        end
        m_r <= mmax_c;
      end
      S_RD_SHIFT: begin
        // One bit per cycle until the largest magnitude sits in [2^29, 2^30).
        if (m_r < M_LOW) begin
          m_r <= m_r << 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
        end else if (m_r >= M_HIGH) begin
          m_r <= m_r >> 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end
        k_r  <= '0;
        sq_r <= '0;
      end
      S_RD_SQ: begin
        sq_r   <= sq_r + 64'(sqr_c);
        x_r    <= sq_r + 64'(sqr_c);
        res_r  <= '0;
        rt_i_r <= 5'd31;
        k_r    <= k_r + 1'b1;
      end
      S_RD_ROOT: begin
        if (root_ge) begin
          x_r <= x_r - trial_c;
        end
        res_r  <= res_c;
        rt_i_r <= rt_i_r - 1'b1;
        r_r    <= res_c[31:0];
        k_r    <= '0;
      end
      S_RD_LDV: begin
        num_r <= {3'b000, mag_r[k_r][29:0], 14'd0} + 47'(r_r >> 1);
        d_r   <= {1'b0, r_r, 14'd0};
        q_r   <= '0;
        di_r  <= 4'd14;
      end
      S_RD_DIV: begin
        if (div_ge) begin
          num_r <= num_r - d_r;
        end
        d_r  <= d_r >> 1;
        q_r  <= qf_c;
        di_r <= di_r - 1'b1;
        if (di_r == '0) begin
          nrm_r[k_r] <= neg_r[k_r] ? (NRM_W'(0) - NRM_W'(qc_c)) : NRM_W'(qc_c);
          k_r        <= k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r.normal_index <= item_r.vertex_index;
      out_data_r.normal_x     <= nrm_r[0];
      out_data_r.normal_y     <= nrm_r[1];
      out_data_r.normal_z     <= nrm_r[2];
    end
  end

`ifndef NO_ASSERTIONS
  // The root of a normalized sum of squares is at least 2^29.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_DIV) |-> (r_r[31:29] != 3'b000))
    else $error("root out of range during divide");

  // Squaring starts only with the largest magnitude in [2^29, 2^30).
  a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_SQ) |-> (m_r[ACC_W-1:29] == 11'd1))
    else $error("normalizing shift incomplete");

  // A new result appears only from the emit state.
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_EMIT))
    else $error("result raised outside emit");
`endif

endmodule
